@@ design/tsws_pkg.sv @@
`default_nettype none
package tsws_pkg;

   localparam int MAX_THREADS_DEF = 16;
   localparam int TICK_WIDTH_DEF  = 32;

   localparam int THREAD_COUNT_W = 5;
   localparam int INDEX_W        = 4;
   localparam int TICK_FIELD_W   = 32;
   localparam int MASK_W         = 16;

   // Request word: thread_index, wake_tick, padded to whole bytes.
   localparam int REQ_BITS   = INDEX_W + TICK_FIELD_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   // Response word: tick_count, switch_required, woken_mask, next_wake, request_error.
   localparam int RSP_BITS   = TICK_FIELD_W + 1 + MASK_W + TICK_FIELD_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_SLEEP = 1'b1;

endpackage
`default_nettype wire

@@ design/tsws_ram.sv @@
`default_nettype none
module tsws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ design/tick_sleep_wakeup_scan.sv @@
`default_nettype none
// A tick word passes through S_TICK and S_DONE, a rejected sleep word goes straight to S_DONE,
// an accepted sleep word passes through S_SLP, S_SLP2 and S_DONE, and a tick word that reaches
// the next wake tick runs a wake scan in S_SCAN before S_DONE, with one
// deadline RAM read per scanned slot through the shared adder. One word is in work at a time;
// req_tready rises with rsp_tvalid, so a new word is taken only once the last one's response is out.
// Synchronous reset clears the tick count, next wake tick and sleep flags; thread_count is one.
module tick_sleep_wakeup_scan #(
   parameter int MAX_THREADS = tsws_pkg::MAX_THREADS_DEF,
   parameter int TICK_WIDTH  = tsws_pkg::TICK_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [tsws_pkg::THREAD_COUNT_W-1:0] csr_wr_data,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // thread_index [3:0], wake_tick [35:4], zero fill above.
   input  wire logic [tsws_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode [0].
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tick_count [31:0], switch_required [32], woken_mask [48:33],
   // next_wake [80:49], request_error [81], zero fill above.
   output logic      [tsws_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import tsws_pkg::*;

   localparam int SLOT_W = $clog2(MAX_THREADS);
   localparam int LIM_W  = SLOT_W + 1;
   localparam int CW     = (LIM_W > THREAD_COUNT_W) ? LIM_W : THREAD_COUNT_W;
   localparam int TW     = TICK_WIDTH;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TICK  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SLP   = 3'd3;
   localparam logic [2:0] S_SLP2  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [THREAD_COUNT_W-1:0] tcount_ff, tcount_in;
   logic [TW-1:0]             cnt_ff, cnt_in;
   logic [TW-1:0]             nxt_ff, nxt_in;
   logic [MAX_THREADS-1:0]    asleep_ff, asleep_in;
   logic [TW-1:0]             wt_ff, wt_in;
   logic [TW-1:0]             best_ff, best_in;
   logic [LIM_W-1:0]          issue_ff, issue_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                      sw_ff, sw_in;
   logic                      err_ff, err_in;
   logic [MASK_W-1:0]         woken_ff, woken_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [INDEX_W-1:0]        req_idx;
   logic [TICK_FIELD_W-1:0]   req_wt;
   logic [TW+TICK_FIELD_W-1:0] wt_wide;
   logic [SLOT_W+INDEX_W-1:0] idx_wide;
   logic [SLOT_W-1:0]         req_slot;
   logic [CW-1:0]             lim_c;
   logic                      bad_slot;
   logic                      req_acc;
   logic                      ram_wr;
   logic [TW-1:0]             ram_rd_data;
   logic [TW-1:0]             add_a;
   logic                      add_cin;
   logic [TW-1:0]             sum;
   logic [TW+TICK_FIELD_W-1:0] cnt_wide, nxt_wide;

   assign req_idx  = req_tdata[INDEX_W-1:0];
   assign req_wt   = req_tdata[INDEX_W +: TICK_FIELD_W];
   assign wt_wide  = {{TW{1'b0}}, req_wt};
   assign idx_wide = {{SLOT_W{1'b0}}, req_idx};
   assign req_slot = idx_wide[SLOT_W-1:0];

   // Slots at or above MAX_THREADS do not exist, whatever thread_count says.
   assign lim_c = (CW'(tcount_ff) >= CW'(MAX_THREADS)) ? CW'(MAX_THREADS) : CW'(tcount_ff);
   assign bad_slot = (req_idx == '0) || (CW'(req_idx) >= lim_c);

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign ram_wr     = req_acc && (req_tuser == MODE_SLEEP) && !bad_slot;

   // Shared adder: x + ~count gives the distance from the tick after the count,
   // and with a carry in it gives the plain distance from the count.
   always_comb begin
      unique case (state_ff)
         S_SCAN:  add_a = ram_rd_data;
         S_SLP2:  add_a = nxt_ff;
         default: add_a = wt_ff;
      endcase
   end
   assign add_cin = (state_ff == S_SCAN);
   assign sum     = add_a + ~cnt_ff + TW'(add_cin);

   assign cnt_wide = {{TICK_FIELD_W{1'b0}}, cnt_ff};
   assign nxt_wide = {{TICK_FIELD_W{1'b0}}, nxt_in};

   tsws_ram #(
      .WIDTH (TW),
      .DEPTH (MAX_THREADS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (req_slot),
      .wr_data (wt_wide[TW-1:0]),
      .rd_addr (issue_ff[SLOT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      tcount_in   = tcount_ff;
      cnt_in      = cnt_ff;
      nxt_in      = nxt_ff;
      asleep_in   = asleep_ff;
      wt_in       = wt_ff;
      best_in     = best_ff;
      issue_in    = issue_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      sw_in       = sw_ff;
      err_in      = err_ff;
      woken_in    = woken_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      if (csr_wr_en) begin
         tcount_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               wt_in    = wt_wide[TW-1:0];
               sw_in    = 1'b0;
               err_in   = 1'b0;
               woken_in = '0;
               if (req_tuser == MODE_TICK) begin
                  cnt_in   = cnt_ff + TW'(1);
                  state_in = S_TICK;
               end else if (bad_slot) begin
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  asleep_in[req_slot] = 1'b1;
                  state_in            = S_SLP;
               end
            end
         end
         S_TICK: begin
            if (cnt_ff == nxt_ff) begin
               sw_in    = 1'b1;
               best_in  = '1;
               issue_in = LIM_W'(1);
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (CW'(issue_ff) < lim_c) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[SLOT_W-1:0];
               issue_in  = issue_ff + LIM_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_DONE;
            end
            if (rd_vld_ff && asleep_ff[rd_idx_ff]) begin
               if (sum == '0) begin
                  asleep_in[rd_idx_ff] = 1'b0;
                  for (int b = 0; b < MASK_W; b++) begin
                     if (int'(rd_idx_ff) == b) begin
                        woken_in[b] = 1'b1;
                     end
                  end
               end else if (sum < best_ff) begin
                  best_in = sum;
                  nxt_in  = ram_rd_data;
               end
            end
         end
         S_SLP: begin
            best_in  = sum;
            state_in = S_SLP2;
         end
         S_SLP2: begin
            // The new deadline takes over only when strictly nearer.
            if (best_ff < sum) begin
               nxt_in = wt_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = RSP_DATA_W'({err_ff, nxt_wide[TICK_FIELD_W-1:0], woken_ff,
                                          sw_ff, cnt_wide[TICK_FIELD_W-1:0]});
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tcount_ff  <= THREAD_COUNT_W'(1);
         cnt_ff     <= '0;
         nxt_ff     <= '0;
         asleep_ff  <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tcount_ff  <= tcount_in;
         cnt_ff     <= cnt_in;
         nxt_ff     <= nxt_in;
         asleep_ff  <= asleep_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      wt_ff       <= wt_in;
      best_ff     <= best_in;
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      sw_ff       <= sw_in;
      err_ff      <= err_in;
      woken_ff    <= woken_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
